// ===== hdl/scanline_segment_profiler_macros.svh =====
// Assertion helpers for the scanline segment profiler.
// All checks run on aclk and are disabled while aresetn is low.
`ifndef SCANLINE_SEGMENT_PROFILER_MACROS_SVH
`define SCANLINE_SEGMENT_PROFILER_MACROS_SVH

// Same-cycle implication
`define SSP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define SSP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/ssp_pkg.sv =====
`timescale 1ns / 1ps

package ssp_pkg;

    // Field widths
    localparam int LINE_W  = 10;
    localparam int TIME_W  = 16;
    localparam int INDEX_W = 6;
    localparam int SLOT_W  = 7;
    localparam int CFG_W   = 10;
    localparam int CFG_IDX_W = 1;

    // Defaults
    localparam int SEGMENTS_DEFAULT = 16;
    localparam logic [CFG_W-1:0] FRAME_LINES_RESET = 10'd525;
    localparam logic [CFG_W-1:0] VSYNC_LINE_RESET  = 10'd480;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LINES = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VSYNC_LINE  = 1'd1;

    // Event codes
    typedef enum logic [1:0] {
        OP_BEGIN_BLOCK = 2'd0,
        OP_END_SEGMENT = 2'd1,
        OP_END_BLOCK   = 2'd2,
        OP_VSYNC       = 2'd3
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [LINE_W-1:0] scanline;
    } in_item_t;

    typedef struct packed {
        logic [TIME_W-1:0]  segment_time;
        logic [INDEX_W-1:0] segment_index;
        logic [TIME_W-1:0]  block_total;
        logic [SLOT_W-1:0]  segment_count;
        logic               last;
    } out_item_t;

    // Controller to datapath
    typedef struct packed {
        logic take;       // capture input item
        logic stamp;      // register the timestamp
        logic begin_blk;  // open a new block
        logic store_seg;  // close a segment into the store
        logic move_mark;  // mark_time follows the timestamp
        logic vsync;      // advance the frame base
        logic clr_idx;    // restart the emit index
        logic rd_en;      // read store at the emit index
        logic load_out;   // load the output register
        logic inc_idx;    // step the emit index
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        op_t  op;
        logic out_free;
        logic last_idx;
    } status_t;

endpackage

// ===== hdl/ssp_ram.sv =====
`timescale 1ns / 1ps

module ssp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                                  aclk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/ssp_ctrl.sv =====
`timescale 1ns / 1ps

module ssp_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  ssp_pkg::status_t sts,
    output ssp_pkg::cmd_t    cmd
);

    import ssp_pkg::*;

`include "scanline_segment_profiler_macros.svh"

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STAMP,
        ST_EXEC,
        ST_READ,
        ST_LOAD
    } state_t;

    state_t state_reg, state_next;

    assign s_ready = (state_reg == ST_IDLE);

    // Next state and datapath commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.take   = 1'b1;
                    state_next = ST_STAMP;
                end
            end
            ST_STAMP: begin
                cmd.stamp  = 1'b1;
                state_next = ST_EXEC;
            end
            ST_EXEC: begin
                state_next = ST_IDLE;
                case (sts.op)
                    OP_BEGIN_BLOCK: cmd.begin_blk = 1'b1;
                    OP_END_SEGMENT: begin
                        cmd.store_seg = 1'b1;
                        cmd.move_mark = 1'b1;
                    end
                    OP_END_BLOCK: begin
                        cmd.store_seg = 1'b1;
                        cmd.clr_idx   = 1'b1;
                        state_next    = ST_READ;
                    end
                    OP_VSYNC: cmd.vsync = 1'b1;
                    default: ;
                endcase
            end
            ST_READ: begin
                cmd.rd_en  = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                // wait for room in the output register
                if (sts.out_free) begin
                    cmd.load_out = 1'b1;
                    if (sts.last_idx) begin
                        state_next = ST_IDLE;
                    end else begin
                        cmd.inc_idx = 1'b1;
                        state_next  = ST_READ;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    `SSP_ASSERT_IMP(a_load_needs_room, cmd.load_out, sts.out_free, "output loaded while full")
    `SSP_ASSERT_NXT(a_read_then_load, state_reg == ST_READ, state_reg == ST_LOAD, "read not followed by load")
    `SSP_ASSERT_IMP(a_take_needs_valid, cmd.take, s_valid && s_ready, "item taken without handshake")

endmodule

// ===== hdl/ssp_datapath.sv =====
`timescale 1ns / 1ps

module ssp_datapath #(
    parameter int SEGMENTS = ssp_pkg::SEGMENTS_DEFAULT
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [ssp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ssp_pkg::CFG_W-1:0]        cfg_wdata,
    input  ssp_pkg::in_item_t                s_item,
    output logic                             m_valid,
    input  logic                             m_ready,
    output ssp_pkg::out_item_t               m_item,
    input  ssp_pkg::cmd_t                    cmd,
    output ssp_pkg::status_t                 sts
);

    import ssp_pkg::*;

`include "scanline_segment_profiler_macros.svh"

    localparam int IDX_W = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;

    logic [CFG_W-1:0]   frame_lines_reg;
    logic [CFG_W-1:0]   vsync_line_reg;
    in_item_t           in_reg;
    logic [TIME_W-1:0]  frame_base_reg;
    logic [TIME_W-1:0]  mark_reg;
    logic [TIME_W-1:0]  stamp_reg;
    logic [TIME_W-1:0]  total_reg;
    logic [SLOT_W-1:0]  next_slot_reg;
    logic [SEGMENTS-1:0] valid_reg;
    logic [IDX_W-1:0]   emit_idx_reg;
    logic               rd_valid_reg;
    logic               m_valid_reg;
    out_item_t          m_item_reg;

    logic [TIME_W-1:0]  rot;
    logic [TIME_W-1:0]  stamp_now;
    logic [TIME_W-1:0]  delta;
    logic               slot_free;
    logic               ram_we;
    logic [IDX_W-1:0]   slot_addr;
    logic [TIME_W-1:0]  rd_data;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_lines_reg <= FRAME_LINES_RESET;
            vsync_line_reg  <= VSYNC_LINE_RESET;
        end else if (cfg_we) begin
            if (cfg_index == CFG_FRAME_LINES) begin
                frame_lines_reg <= cfg_wdata;
            end
            if (cfg_index == CFG_VSYNC_LINE) begin
                vsync_line_reg <= cfg_wdata;
            end
        end
    end

    // Input item capture
    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            in_reg <= s_item;
        end
    end

    // Timestamp: scanline rotated so vsync lands on zero, plus frame base
    always_comb begin
        rot = TIME_W'(in_reg.scanline) - TIME_W'(vsync_line_reg);
        if (in_reg.scanline < vsync_line_reg) begin
            rot = rot + TIME_W'(frame_lines_reg);
        end
        stamp_now = frame_base_reg + rot;
    end

    always_ff @(posedge aclk) begin
        if (cmd.stamp) begin
            stamp_reg <= stamp_now;
        end
    end

    // Segment close
    assign delta     = stamp_reg - mark_reg;
    assign slot_free = (next_slot_reg < SLOT_W'(SEGMENTS));
    assign ram_we    = cmd.store_seg && slot_free;
    assign slot_addr = next_slot_reg[IDX_W-1:0];

    // Block state; the running total tracks the store since slots fill in order
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_base_reg <= '0;
            mark_reg       <= '0;
            next_slot_reg  <= '0;
            total_reg      <= '0;
            valid_reg      <= '0;
        end else begin
            if (cmd.vsync) begin
                frame_base_reg <= frame_base_reg + TIME_W'(frame_lines_reg);
            end
            if (cmd.begin_blk || cmd.move_mark) begin
                mark_reg <= stamp_reg;
            end
            if (cmd.begin_blk) begin
                next_slot_reg <= '0;
                total_reg     <= '0;
                valid_reg     <= '0;
            end else if (ram_we) begin
                next_slot_reg        <= next_slot_reg + 1'b1;
                total_reg            <= total_reg + delta;
                valid_reg[slot_addr] <= 1'b1;
            end
        end
    end

    ssp_ram #(
        .WIDTH (TIME_W),
        .DEPTH (SEGMENTS)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (slot_addr),
        .wdata (delta),
        .re    (cmd.rd_en),
        .raddr (emit_idx_reg),
        .rdata (rd_data)
    );

    // Emit index and the valid bit matching the registered read
    always_ff @(posedge aclk) begin
        if (cmd.clr_idx) begin
            emit_idx_reg <= '0;
        end else if (cmd.inc_idx) begin
            emit_idx_reg <= emit_idx_reg + 1'b1;
        end
        if (cmd.rd_en) begin
            rd_valid_reg <= valid_reg[emit_idx_reg];
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_item_reg.segment_time  <= rd_valid_reg ? rd_data : '0;
            m_item_reg.segment_index <= INDEX_W'(emit_idx_reg);
            m_item_reg.block_total   <= total_reg;
            m_item_reg.segment_count <= next_slot_reg;
            m_item_reg.last          <= sts.last_idx;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    assign sts.op       = in_reg.op;
    assign sts.out_free = !m_valid_reg || m_ready;
    assign sts.last_idx = (emit_idx_reg == IDX_W'(SEGMENTS - 1));

    `SSP_ASSERT_IMP(a_slot_bound, 1'b1, next_slot_reg <= SLOT_W'(SEGMENTS), "slot count past store")
    `SSP_ASSERT_IMP(a_write_in_range, ram_we, slot_addr < IDX_W'(SEGMENTS - 1) || slot_addr == IDX_W'(SEGMENTS - 1), "store write out of range")
    `SSP_ASSERT_NXT(a_begin_clears, cmd.begin_blk, total_reg == '0 && valid_reg == '0 && next_slot_reg == '0, "begin block left state")

endmodule

// ===== hdl/scanline_segment_profiler.sv =====
`timescale 1ns / 1ps

// Scanline segment profiler. Each input item carries an event code and the
// raster scanline current at that event; timestamps count scanlines from
// vsync plus a 16-bit frame base that each vsync tick advances by
// frame_lines. Begin block, end segment and vsync tick produce no result
// and each pass through accept, timestamp and execute steps. End block
// closes the last segment and then emits SEGMENTS results, one per store
// entry, with last set on the final one; each entry goes through the single
// registered read port of the segment store and then the output register,
// and no new item is taken until the last entry is loaded. The store is
// cleared through per-entry valid bits, so reset and begin block need no
// clearing pass. New items are accepted while a result still waits in the
// output register. Configuration (index 0 frame_lines, index 1 vsync_line)
// must be written only while no item is in progress; the block itself does
// not enforce this.
module scanline_segment_profiler #(
    parameter int SEGMENTS = ssp_pkg::SEGMENTS_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [ssp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ssp_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  ssp_pkg::in_item_t             s_item,
    output logic                          m_valid,
    input  logic                          m_ready,
    output ssp_pkg::out_item_t            m_item
);

    import ssp_pkg::*;

    cmd_t    cmd;
    status_t sts;

    ssp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    ssp_datapath #(
        .SEGMENTS (SEGMENTS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

// ===== tb/sv/tb_scanline_segment_profiler.sv =====
`timescale 1ns / 1ps

module tb_scanline_segment_profiler;
    import ssp_pkg::*;

    localparam int SEGMENTS      = SEGMENTS_DEFAULT;
    localparam int IDX_W         = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
    localparam int CYCLE_LIMIT   = 300000;
    localparam int SETTLE_CYCLES = 12;
    localparam int LONG_HOLD     = 300;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;
    logic                 s_valid;
    logic                 s_ready;
    in_item_t             s_item;
    logic                 m_valid;
    logic                 m_ready;
    out_item_t            m_item;

    always #2 aclk = ~aclk;

    scanline_segment_profiler #(.SEGMENTS(SEGMENTS)) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

    // Shadow copy of the profiler: registers, timebase and segment store
    logic [CFG_W-1:0]  lines_per_frame;
    logic [CFG_W-1:0]  vsync_at;
    logic [TIME_W-1:0] frame_base;
    logic [TIME_W-1:0] mark_time;
    logic [SLOT_W-1:0] next_slot;
    logic [TIME_W-1:0] seg_store [SEGMENTS];

    // Segment reports still owed by the block, oldest first
    out_item_t segment_reports_due [$];

    int  errors = 0;
    int  items_sent = 0;
    int  runs_closed = 0;
    int  results_seen = 0;
    int  settings_used = 1;
    int  cycles = 0;
    bit  quiet_sender = 1'b0;
    bit  hold_req = 1'b0;
    bit  hold_taken = 1'b0;

    // Directed rows; typed rows carry the values readable straight off the spec
    typedef struct {
        in_item_t          item;
        bit                typed;
        logic [TIME_W-1:0] first_time;
        logic [TIME_W-1:0] total;
        logic [SLOT_W-1:0] count;
    } directed_row_t;

    directed_row_t plan [$];

    function automatic in_item_t mk(op_t op, logic [LINE_W-1:0] line);
        in_item_t it;
        it.op = op;
        it.scanline = line;
        return it;
    endfunction

    function automatic void add_row(op_t op, int line, bit typed, int first_time,
                                    int total, int count);
        directed_row_t row;
        row.item = mk(op, line[LINE_W-1:0]);
        row.typed = typed;
        row.first_time = first_time[TIME_W-1:0];
        row.total = total[TIME_W-1:0];
        row.count = count[SLOT_W-1:0];
        plan.push_back(row);
    endfunction

    // Scanline rotated so vsync lands on zero, on top of the frame base
    function automatic logic [TIME_W-1:0] raster_stamp(logic [LINE_W-1:0] line);
        logic [TIME_W-1:0] l16, v16, f16, rot;
        l16 = TIME_W'(line);
        v16 = TIME_W'(vsync_at);
        f16 = TIME_W'(lines_per_frame);
        if (line >= vsync_at) begin
            rot = l16 - v16;
        end else begin
            rot = l16 + f16 - v16;
        end
        return frame_base + rot;
    endfunction

    // Store one segment duration unless the store is already full
    task automatic close_segment(logic [TIME_W-1:0] t);
        if (next_slot < SLOT_W'(SEGMENTS)) begin
            seg_store[next_slot[IDX_W-1:0]] = t - mark_time;
            next_slot = next_slot + 1'b1;
        end
    endtask

    // Advance the shadow state by one accepted item, queue any segment reports
    task automatic profile_event(in_item_t it);
        logic [TIME_W-1:0] t;
        logic [TIME_W-1:0] total;
        out_item_t         r;
        t = raster_stamp(it.scanline);
        case (it.op)
            OP_BEGIN_BLOCK: begin
                foreach (seg_store[i]) seg_store[i] = '0;
                mark_time = t;
                next_slot = '0;
            end
            OP_END_SEGMENT: begin
                close_segment(t);
                mark_time = t;
            end
            OP_VSYNC: begin
                frame_base = frame_base + TIME_W'(lines_per_frame);
            end
            OP_END_BLOCK: begin
                close_segment(t);
                total = '0;
                foreach (seg_store[i]) total = total + seg_store[i];
                foreach (seg_store[i]) begin
                    r.segment_time  = seg_store[i];
                    r.segment_index = i[INDEX_W-1:0];
                    r.block_total   = total;
                    r.segment_count = next_slot;
                    r.last          = (i == SEGMENTS - 1);
                    segment_reports_due.push_back(r);
                end
                runs_closed++;
            end
            default: ;
        endcase
    endtask

    // Offer one item; returns at the edge where it is taken
    task automatic send_item(in_item_t it);
        int gap;
        gap = quiet_sender ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    task automatic offer(in_item_t it);
        send_item(it);
        profile_event(it);
    endtask

    // Stop offering until every owed report has come out
    task automatic wait_for_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (segment_reports_due.size() != 0);
    endtask

    // Registers change only with the block idle
    task automatic settle_and_configure(logic [CFG_W-1:0] lines, logic [CFG_W-1:0] vs);
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_FRAME_LINES;
        cfg_wdata <= lines;
        @(posedge aclk);
        cfg_index <= CFG_VSYNC_LINE;
        cfg_wdata <= vs;
        @(posedge aclk);
        cfg_we <= 1'b0;
        lines_per_frame = lines;
        vsync_at = vs;
        settings_used++;
    endtask

    // Lines biased toward the edges and the vsync line itself
    function automatic logic [LINE_W-1:0] pick_line();
        logic [LINE_W-1:0] v;
        case ($urandom_range(0, 7))
            0: v = '0;
            1: v = '1;
            2: v = vsync_at;
            default: v = LINE_W'($urandom);
        endcase
        return v;
    endfunction

    // Mostly whole blocks with random content, some stray events
    task automatic random_phase(int n_items, bit pause_mid);
        int stop_at;
        int k;
        bit paused;
        stop_at = items_sent + n_items;
        paused = 1'b0;
        while (items_sent < stop_at) begin
            if ($urandom_range(0, 9) < 7) begin
                offer(mk(OP_BEGIN_BLOCK, pick_line()));
                k = ($urandom_range(0, 5) == 0) ? $urandom_range(14, 20) : $urandom_range(0, 5);
                repeat (k) begin
                    if ($urandom_range(0, 3) == 0) offer(mk(OP_VSYNC, pick_line()));
                    offer(mk(OP_END_SEGMENT, pick_line()));
                end
                offer(mk(OP_END_BLOCK, pick_line()));
                // appending to a closed block
                if ($urandom_range(0, 4) == 0) offer(mk(OP_END_BLOCK, pick_line()));
            end else begin
                offer(mk(op_t'($urandom_range(0, 3)), pick_line()));
            end
            if (pause_mid && !paused && items_sent >= stop_at - n_items / 2) begin
                paused = 1'b1;
                wait_for_results();
            end
        end
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    // Compare every taken result with the oldest owed report
    always @(posedge aclk) begin : result_check
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (segment_reports_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, got time %0d index %0d",
                         $time, m_item.segment_time, m_item.segment_index);
            end else begin
                want = segment_reports_due.pop_front();
                check_field("segment_time", 32'(want.segment_time), 32'(m_item.segment_time));
                check_field("segment_index", 32'(want.segment_index),
                            32'(m_item.segment_index));
                check_field("block_total", 32'(want.block_total), 32'(m_item.block_total));
                check_field("segment_count", 32'(want.segment_count),
                            32'(m_item.segment_count));
                check_field("last", 32'(want.last), 32'(m_item.last));
            end
        end
    end

    // Result side: random stalls, calm stretches, one long hold-off
    initial begin : result_sink
        int stall;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                stall = LONG_HOLD;
            end else if ((results_seen / 48) % 3 == 1) begin
                stall = 0;
            end else begin
                stall = $urandom_range(0, 3);
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin : stimulus
        directed_row_t     row;
        int                n;
        logic [CFG_W-1:0]  rnd_lines;
        logic [CFG_W-1:0]  rnd_vs;

        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = CFG_FRAME_LINES;
        cfg_wdata = '0;
        s_valid   = 1'b0;
        s_item    = '0;
        lines_per_frame = FRAME_LINES_RESET;
        vsync_at        = VSYNC_LINE_RESET;
        frame_base = '0;
        mark_time  = '0;
        next_slot  = '0;
        foreach (seg_store[i]) seg_store[i] = '0;

        // Directed part, reset settings: 525 lines, vsync at 480
        add_row(OP_END_BLOCK, 480, 1'b1, 0, 0, 1);        // straight after reset
        add_row(OP_BEGIN_BLOCK, 480, 1'b0, 0, 0, 0);
        add_row(OP_END_SEGMENT, 1023, 1'b0, 0, 0, 0);     // top scanline
        add_row(OP_END_SEGMENT, 0, 1'b0, 0, 0, 0);        // below vsync, negative step
        add_row(OP_VSYNC, 'h2AA, 1'b0, 0, 0, 0);
        add_row(OP_END_BLOCK, 480, 1'b1, 543, 525, 3);    // total wraps
        add_row(OP_END_BLOCK, 480, 1'b0, 0, 0, 0);        // appends without begin
        add_row(OP_BEGIN_BLOCK, 480, 1'b0, 0, 0, 0);
        for (int i = 0; i < SEGMENTS - 1; i++) add_row(OP_END_SEGMENT, 481, 1'b0, 0, 0, 0);
        add_row(OP_END_BLOCK, 481, 1'b1, 1, 1, SEGMENTS); // fills the last slot
        add_row(OP_END_BLOCK, 1023, 1'b1, 1, 1, SEGMENTS); // store full, dropped

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan[i]) begin
            row = plan[i];
            send_item(row.item);
            profile_event(row.item);
            if (row.typed) begin
                n = segment_reports_due.size();
                for (int j = n - SEGMENTS; j < n; j++) begin
                    segment_reports_due[j].block_total   = row.total;
                    segment_reports_due[j].segment_count = row.count;
                end
                segment_reports_due[n - SEGMENTS].segment_time = row.first_time;
            end
        end

        // Random part over several register settings
        settle_and_configure(10'd1, 10'd0);
        random_phase(18, 1'b0);

        settle_and_configure(10'd1023, 10'd1023);
        random_phase(18, 1'b1);

        // back-to-back items while the result side holds off
        settle_and_configure(10'd1023, 10'd0);
        quiet_sender = 1'b1;
        hold_req = 1'b1;
        random_phase(18, 1'b0);
        quiet_sender = 1'b0;

        rnd_lines = CFG_W'($urandom_range(1, 1023));
        rnd_vs    = CFG_W'($urandom_range(0, 1023));
        settle_and_configure(rnd_lines, rnd_vs);
        random_phase(18, 1'b0);

        settle_and_configure(FRAME_LINES_RESET, VSYNC_LINE_RESET);
        random_phase(18, 1'b0);

        wait_for_results();
        repeat (40) @(posedge aclk);

        $display("Sent %0d events in %0d register settings; %0d end-block runs, %0d results.",
                 items_sent, settings_used, runs_closed, results_seen);
        $display("Included store overflow, wrapping totals, a long output hold and a drain.");
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/ssp_pkg.sv
hdl/ssp_ram.sv
hdl/ssp_ctrl.sv
hdl/ssp_datapath.sv
hdl/scanline_segment_profiler.sv
tb/sv/tb_scanline_segment_profiler.sv
